// ----- rtl/core/triggered_capture_linear_upsampler_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef TRIGGERED_CAPTURE_LINEAR_UPSAMPLER_CORE_ASSERT_SVH
`define TRIGGERED_CAPTURE_LINEAR_UPSAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tcu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tcu assertion failed");

`endif

// ----- rtl/core/tcu_pkg.sv -----
// ----------------------------------------------------------------------------
// tcu_pkg
// Shared constants, codes and types of the triggered capture upsampler.
// ----------------------------------------------------------------------------
package tcu_pkg;

    localparam int CAPTURE_DEPTH = 4096;
    localparam int FRAC_BITS     = 24;

    localparam int ADDR_W     = $clog2(CAPTURE_DEPTH);
    localparam int CAP_W      = ADDR_W + 1;
    localparam int SAMPLE_W   = 12;
    localparam int PCM_W      = 16;
    localparam int CAPLEN_W   = 13;
    localparam int OUTLEN_W   = 14;
    localparam int OUTIDX_W   = OUTLEN_W - 1;
    localparam int STEP_W     = 28;
    localparam int OUT_LEN_MAX = 8192;

    // position accumulator: integer part wide enough for the last index plus one step
    localparam int STEP_INT_W = (STEP_W > FRAC_BITS) ? (STEP_W - FRAC_BITS) : 1;
    localparam int IP_W       = ((ADDR_W > STEP_INT_W) ? ADDR_W : STEP_INT_W) + 1;
    localparam int POS_W      = IP_W + FRAC_BITS;

    // (b - a) * frac: 17-bit signed times unsigned fraction
    localparam int PROD_W     = PCM_W + 1 + FRAC_BITS + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = STEP_W;

    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MID_CODE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LEN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP         = 3'd5;

    localparam logic [SAMPLE_W-1:0] TRIGGER_LOW_RST  = 12'd1548;
    localparam logic [SAMPLE_W-1:0] TRIGGER_HIGH_RST = 12'd2548;
    localparam logic [SAMPLE_W-1:0] MID_CODE_RST     = 12'd2048;
    localparam logic [CAPLEN_W-1:0] CAPTURE_LEN_RST  = 13'd3807;
    localparam logic [OUTLEN_W-1:0] OUT_LEN_RST      = 14'd6768;
    localparam logic [STEP_W-1:0]   STEP_RST         = 28'd9436099;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAPTURE,
        ST_EMIT,
        ST_RD_A,
        ST_RD_B,
        ST_MUL
    } state_t;

    typedef struct packed {
        logic a_load;
        logic mul_load;
    } interp_ctrl_t;

endpackage

// ----- rtl/core/triggered_capture_linear_upsampler_core.sv -----
// ----------------------------------------------------------------------------
// triggered_capture_linear_upsampler_core
// Triggered 12-bit capture into a sample memory, replayed linearly resampled.
// ----------------------------------------------------------------------------
// Usage: present an ADC sample with start high; it is taken when busy is low.
// While idle or capturing, busy stays low and every transaction completes as
// it is taken. Once the capture is full, the next sample is dropped, and each
// further transaction yields one resampled point: busy is high while the two
// reads of the capture memory (one read port, registered read data) and the
// multiply stage run, and the result then appears on out_sample/last with
// out_valid high for exactly one cycle. The next sample can be taken in that
// same cycle, so a point is not started before the last one is delivered.
// There is no backpressure: the receiver must take out_valid whenever it
// shows. The capture memory has no reset; only entries written in the
// current capture are read. Configuration writes (cfg_ready is always high)
// must be done while idle; lengths and step are latched when a capture arms,
// so later writes take effect on the next capture.
// ----------------------------------------------------------------------------
module triggered_capture_linear_upsampler_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample transactions
    input  logic                            start,
    output logic                            busy,
    input  logic [tcu_pkg::SAMPLE_W-1:0]    adc_sample,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcu_pkg::CFG_DATA_W-1:0]  cfg_data,
    // results
    output logic                            out_valid,
    output logic signed [tcu_pkg::PCM_W-1:0] out_sample,
    output logic                            last
);

    // configuration registers
    logic [tcu_pkg::SAMPLE_W-1:0] trigger_low_reg,  trigger_low_next;
    logic [tcu_pkg::SAMPLE_W-1:0] trigger_high_reg, trigger_high_next;
    logic [tcu_pkg::SAMPLE_W-1:0] mid_code_reg,     mid_code_next;
    logic [tcu_pkg::CAPLEN_W-1:0] capture_len_reg,  capture_len_next;
    logic [tcu_pkg::OUTLEN_W-1:0] out_len_reg,      out_len_next;
    logic [tcu_pkg::STEP_W-1:0]   step_reg,         step_next;

    // capture control, latched at arming
    tcu_pkg::state_t              state_reg, state_next;
    logic [tcu_pkg::CAP_W-1:0]    lat_cap_reg,  lat_cap_next;
    logic [tcu_pkg::OUTLEN_W-1:0] lat_out_reg,  lat_out_next;
    logic [tcu_pkg::STEP_W-1:0]   lat_step_reg, lat_step_next;
    logic [tcu_pkg::CAP_W-1:0]    fill_reg,     fill_next;
    logic [tcu_pkg::OUTIDX_W-1:0] out_idx_reg,  out_idx_next;
    logic [tcu_pkg::POS_W-1:0]    pos_reg,      pos_next;

    // per-point working registers
    logic [tcu_pkg::ADDR_W-1:0]    rd_addr_reg,   rd_addr_next;
    logic [tcu_pkg::FRAC_BITS-1:0] frac_reg,      frac_next;
    logic                          item_last_reg, item_last_next;

    // result registers
    logic                        out_valid_reg,  out_valid_next;
    logic [tcu_pkg::PCM_W-1:0]   out_sample_reg, out_sample_next;
    logic                        last_reg,       last_next;

    // memory and datapath hookup
    logic                        mem_we;
    logic [tcu_pkg::ADDR_W-1:0]  mem_waddr;
    logic [tcu_pkg::PCM_W-1:0]   mem_wdata;
    logic                        mem_re;
    logic [tcu_pkg::ADDR_W-1:0]  mem_raddr;
    logic [tcu_pkg::PCM_W-1:0]   mem_rdata;
    tcu_pkg::interp_ctrl_t       interp_ctrl;
    logic [tcu_pkg::PCM_W-1:0]   interp_result;

    logic                         accept;
    logic                         trig;
    logic [tcu_pkg::SAMPLE_W-1:0] centered;
    logic [tcu_pkg::CAP_W-1:0]    cap_clamped;
    logic [tcu_pkg::OUTLEN_W-1:0] out_clamped;
    logic [tcu_pkg::IP_W-1:0]     ip;
    logic [tcu_pkg::CAP_W-1:0]    end_idx;
    logic                         at_end;
    logic [tcu_pkg::OUTLEN_W-1:0] out_idx_inc;

    assign busy      = (state_reg == tcu_pkg::ST_RD_A) || (state_reg == tcu_pkg::ST_RD_B)
                    || (state_reg == tcu_pkg::ST_MUL);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign last       = last_reg;

    // arming test and centered PCM: (sample - mid) * 16 keeps the low 12 bits of the diff
    assign trig      = (adc_sample < trigger_low_reg) || (adc_sample > trigger_high_reg);
    assign centered  = adc_sample - mid_code_reg;
    assign mem_wdata = {centered, 4'b0000};

    // length clamps applied at arming
    always_comb
    begin
        if (32'(capture_len_reg) > tcu_pkg::CAPTURE_DEPTH)
        begin
            cap_clamped = tcu_pkg::CAP_W'(tcu_pkg::CAPTURE_DEPTH);
        end
        else if (capture_len_reg < tcu_pkg::CAPLEN_W'(2))
        begin
            cap_clamped = tcu_pkg::CAP_W'(2);
        end
        else
        begin
            cap_clamped = tcu_pkg::CAP_W'(capture_len_reg);
        end

        if (out_len_reg > tcu_pkg::OUTLEN_W'(tcu_pkg::OUT_LEN_MAX))
        begin
            out_clamped = tcu_pkg::OUTLEN_W'(tcu_pkg::OUT_LEN_MAX);
        end
        else if (out_len_reg < tcu_pkg::OUTLEN_W'(2))
        begin
            out_clamped = tcu_pkg::OUTLEN_W'(2);
        end
        else
        begin
            out_clamped = out_len_reg;
        end
    end

    // current point position; past the last pair it holds on the last entry
    assign ip          = pos_reg[tcu_pkg::POS_W-1:tcu_pkg::FRAC_BITS];
    assign end_idx     = lat_cap_reg - tcu_pkg::CAP_W'(1);
    assign at_end      = ip >= tcu_pkg::IP_W'(end_idx);
    assign out_idx_inc = {1'b0, out_idx_reg} + tcu_pkg::OUTLEN_W'(1);

    // configuration write port
    always_comb
    begin
        trigger_low_next  = trigger_low_reg;
        trigger_high_next = trigger_high_reg;
        mid_code_next     = mid_code_reg;
        capture_len_next  = capture_len_reg;
        out_len_next      = out_len_reg;
        step_next         = step_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tcu_pkg::REG_TRIGGER_LOW:  trigger_low_next  = cfg_data[tcu_pkg::SAMPLE_W-1:0];
                tcu_pkg::REG_TRIGGER_HIGH: trigger_high_next = cfg_data[tcu_pkg::SAMPLE_W-1:0];
                tcu_pkg::REG_MID_CODE:     mid_code_next     = cfg_data[tcu_pkg::SAMPLE_W-1:0];
                tcu_pkg::REG_CAPTURE_LEN:  capture_len_next  = cfg_data[tcu_pkg::CAPLEN_W-1:0];
                tcu_pkg::REG_OUT_LEN:      out_len_next      = cfg_data[tcu_pkg::OUTLEN_W-1:0];
                tcu_pkg::REG_STEP:         step_next         = cfg_data[tcu_pkg::STEP_W-1:0];
                default:                   ; // unknown index: ignored
            endcase
        end
    end

    // sequencer: capture writes, then two reads, multiply and round per point
    always_comb
    begin
        state_next      = state_reg;
        lat_cap_next    = lat_cap_reg;
        lat_out_next    = lat_out_reg;
        lat_step_next   = lat_step_reg;
        fill_next       = fill_reg;
        out_idx_next    = out_idx_reg;
        pos_next        = pos_reg;
        rd_addr_next    = rd_addr_reg;
        frac_next       = frac_reg;
        item_last_next  = item_last_reg;
        out_valid_next  = 1'b0;
        out_sample_next = out_sample_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = fill_reg[tcu_pkg::ADDR_W-1:0];
        mem_re          = 1'b0;
        mem_raddr       = rd_addr_reg + tcu_pkg::ADDR_W'(1);
        interp_ctrl     = '0;

        case (state_reg)
            tcu_pkg::ST_IDLE:
            begin
                if (accept && trig)
                begin
                    // arming sample is the first one stored
                    lat_cap_next  = cap_clamped;
                    lat_out_next  = out_clamped;
                    lat_step_next = step_reg;
                    mem_we        = 1'b1;
                    mem_waddr     = '0;
                    fill_next     = tcu_pkg::CAP_W'(1);
                    out_idx_next  = '0;
                    pos_next      = '0;
                    state_next    = tcu_pkg::ST_CAPTURE;
                end
            end

            tcu_pkg::ST_CAPTURE:
            begin
                if (accept)
                begin
                    if (fill_reg < lat_cap_reg)
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + tcu_pkg::CAP_W'(1);
                    end
                    else
                    begin
                        // full: this sample is dropped
                        out_idx_next = '0;
                        pos_next     = '0;
                        state_next   = tcu_pkg::ST_EMIT;
                    end
                end
            end

            tcu_pkg::ST_EMIT:
            begin
                if (accept)
                begin
                    mem_re = 1'b1;
                    if (at_end)
                    begin
                        // zero fraction makes the result the last entry
                        mem_raddr = end_idx[tcu_pkg::ADDR_W-1:0];
                        frac_next = '0;
                    end
                    else
                    begin
                        mem_raddr = ip[tcu_pkg::ADDR_W-1:0];
                        frac_next = pos_reg[tcu_pkg::FRAC_BITS-1:0];
                    end
                    rd_addr_next = mem_raddr;
                    if (out_idx_inc >= lat_out_reg)
                    begin
                        item_last_next = 1'b1;
                        fill_next      = '0;
                        out_idx_next   = '0;
                        pos_next       = '0;
                    end
                    else
                    begin
                        item_last_next = 1'b0;
                        out_idx_next   = out_idx_reg + tcu_pkg::OUTIDX_W'(1);
                        if (!at_end)
                        begin
                            pos_next = pos_reg + tcu_pkg::POS_W'(lat_step_reg);
                        end
                    end
                    state_next = tcu_pkg::ST_RD_A;
                end
            end

            tcu_pkg::ST_RD_A:
            begin
                // entry a arrives; fetch its neighbor
                interp_ctrl.a_load = 1'b1;
                mem_re             = 1'b1;
                // with a zero fraction b drops out: reread a, its neighbor may be unwritten
                if (frac_reg == '0)
                begin
                    mem_raddr = rd_addr_reg;
                end
                state_next         = tcu_pkg::ST_RD_B;
            end

            tcu_pkg::ST_RD_B:
            begin
                interp_ctrl.mul_load = 1'b1;
                state_next           = tcu_pkg::ST_MUL;
            end

            tcu_pkg::ST_MUL:
            begin
                out_valid_next  = 1'b1;
                out_sample_next = interp_result;
                last_next       = item_last_reg;
                state_next      = item_last_reg ? tcu_pkg::ST_IDLE : tcu_pkg::ST_EMIT;
            end

            default:
            begin
                state_next = tcu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_low_reg  <= tcu_pkg::TRIGGER_LOW_RST;
            trigger_high_reg <= tcu_pkg::TRIGGER_HIGH_RST;
            mid_code_reg     <= tcu_pkg::MID_CODE_RST;
            capture_len_reg  <= tcu_pkg::CAPTURE_LEN_RST;
            out_len_reg      <= tcu_pkg::OUT_LEN_RST;
            step_reg         <= tcu_pkg::STEP_RST;
            state_reg        <= tcu_pkg::ST_IDLE;
            lat_cap_reg      <= tcu_pkg::CAP_W'(2);
            lat_out_reg      <= tcu_pkg::OUTLEN_W'(2);
            lat_step_reg     <= tcu_pkg::STEP_RST;
            fill_reg         <= '0;
            out_idx_reg      <= '0;
            pos_reg          <= '0;
            item_last_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            trigger_low_reg  <= trigger_low_next;
            trigger_high_reg <= trigger_high_next;
            mid_code_reg     <= mid_code_next;
            capture_len_reg  <= capture_len_next;
            out_len_reg      <= out_len_next;
            step_reg         <= step_next;
            state_reg        <= state_next;
            lat_cap_reg      <= lat_cap_next;
            lat_out_reg      <= lat_out_next;
            lat_step_reg     <= lat_step_next;
            fill_reg         <= fill_next;
            out_idx_reg      <= out_idx_next;
            pos_reg          <= pos_next;
            item_last_reg    <= item_last_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        rd_addr_reg    <= rd_addr_next;
        frac_reg       <= frac_next;
        out_sample_reg <= out_sample_next;
        last_reg       <= last_next;
    end

    tcu_ram #(
        .WIDTH (tcu_pkg::PCM_W),
        .DEPTH (tcu_pkg::CAPTURE_DEPTH)
    ) u_capture_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcu_interp u_interp (
        .clk     (clk),
        .ctrl    (interp_ctrl),
        .frac    (frac_reg),
        .rd_data (mem_rdata),
        .result  (interp_result)
    );

endmodule

// ----- rtl/core/tcu_ram.sv -----
// ----------------------------------------------------------------------------
// tcu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tcu_interp.sv -----
// ----------------------------------------------------------------------------
// tcu_interp
// Linear interpolation datapath: a + round((b - a) * frac).
// ----------------------------------------------------------------------------
module tcu_interp (
    input  logic                           clk,
    input  tcu_pkg::interp_ctrl_t          ctrl,
    input  logic [tcu_pkg::FRAC_BITS-1:0]  frac,
    input  logic [tcu_pkg::PCM_W-1:0]      rd_data,
    output logic [tcu_pkg::PCM_W-1:0]      result
);

    localparam logic signed [tcu_pkg::PROD_W-1:0] HALF =
        tcu_pkg::PROD_W'(1) << (tcu_pkg::FRAC_BITS - 1);

    logic        [tcu_pkg::PCM_W-1:0]  a_reg;
    logic signed [tcu_pkg::PROD_W-1:0] prod_reg;
    logic signed [tcu_pkg::PCM_W:0]    diff;
    logic signed [tcu_pkg::FRAC_BITS:0] frac_s;
    logic signed [tcu_pkg::PROD_W-1:0] prod_next;
    logic signed [tcu_pkg::PROD_W-1:0] rounded;
    logic signed [tcu_pkg::PROD_W-1:0] q;

    always_comb
    begin
        diff      = $signed({rd_data[tcu_pkg::PCM_W-1], rd_data})
                  - $signed({a_reg[tcu_pkg::PCM_W-1], a_reg});
        frac_s    = $signed({1'b0, frac});
        prod_next = diff * frac_s;
        rounded   = prod_reg + HALF;
        // arithmetic shift gives floor, matching round half up
        q         = rounded >>> tcu_pkg::FRAC_BITS;
        result    = a_reg + q[tcu_pkg::PCM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.a_load)
        begin
            a_reg <= rd_data;
        end
        if (ctrl.mul_load)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

// ----- rtl/core/triggered_capture_linear_upsampler_core_checker.sv -----
// ----------------------------------------------------------------------------
// triggered_capture_linear_upsampler_core_checker
// Port-level checks of transaction timing, bound to the core.
// ----------------------------------------------------------------------------
`include "triggered_capture_linear_upsampler_core_assert.svh"

module triggered_capture_linear_upsampler_core_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             out_valid
);

    // a result shows as the block frees up
    `TCU_ASSERT_IMP(a_result_not_busy, clk, rst_n, out_valid, !busy)
    // results are single-cycle strobes, never back to back
    `TCU_ASSERT_NXT(a_result_strobe, clk, rst_n, out_valid, !out_valid)
    // busy only starts from an accepted transaction
    `TCU_ASSERT_IMP(a_busy_from_start, clk, rst_n, $rose(busy), $past(start))
    // busy ends only by delivering a result
    `TCU_ASSERT_NXT(a_busy_to_result, clk, rst_n, busy, busy || out_valid)

endmodule

bind triggered_capture_linear_upsampler_core
    triggered_capture_linear_upsampler_core_checker u_checker (.*);
